>>> src/bhwdm_pkg.sv
// Package for the byte/half/word data memory: sizes, access codes and port types.
package bhwdm_pkg;

	// Memory size in bytes and derived word geometry
	localparam int unsigned MEM_BYTES  = 1024;
	localparam int unsigned WORD_DEPTH = (MEM_BYTES + 3) / 4;
	localparam int unsigned IDX_W      = $clog2(WORD_DEPTH);

	// Range limits for byte, half and word indexes
	localparam logic [31:0] BYTE_LIMIT = 32'(MEM_BYTES);
	localparam logic [30:0] HALF_LIMIT = 31'(MEM_BYTES / 2);
	localparam logic [29:0] WORD_LIMIT = 30'(MEM_BYTES / 4);

	// Access codes
	localparam logic [2:0] KIND_SB  = 3'd0;
	localparam logic [2:0] KIND_SH  = 3'd1;
	localparam logic [2:0] KIND_SW  = 3'd2;
	localparam logic [2:0] KIND_LB  = 3'd3;
	localparam logic [2:0] KIND_LH  = 3'd4;
	localparam logic [2:0] KIND_LW  = 3'd5;
	localparam logic [2:0] KIND_LBU = 3'd6;
	localparam logic [2:0] KIND_LHU = 3'd7;

	typedef logic [IDX_W-1:0] word_idx_t;

	// Write request into the word store
	typedef struct packed {
		logic        en;
		logic [3:0]  be;
		word_idx_t   idx;
		logic [31:0] data;
	} wr_req_t;

	// Read request into the word store
	typedef struct packed {
		logic      en;
		word_idx_t idx;
	} rd_req_t;

endpackage

>>> src/bhwdm_store.sv
// Word store with byte-lane writes, registered read and per-word valid flags.
module bhwdm_store (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bhwdm_pkg::wr_req_t    wr,
	input  bhwdm_pkg::rd_req_t    rd,
	output logic [31:0]           rd_word_s1,
	output logic                  rd_vld_s1
);

	logic [31:0] mem [bhwdm_pkg::WORD_DEPTH];
	logic [bhwdm_pkg::WORD_DEPTH-1:0] valid_q;

	// Lane writes; a word never written before gets its other lanes zeroed
	always_ff @(posedge clk) begin
		if (wr.en) begin
			for (int i = 0; i < 4; i++) begin
				if (wr.be[i]) begin
					mem[wr.idx][8*i +: 8] <= wr.data[8*i +: 8];
				end else if (!valid_q[wr.idx]) begin
					mem[wr.idx][8*i +: 8] <= 8'h00;
				end
			end
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_word_s1 <= mem[rd.idx];
		end
	end

	// Valid flags stand in for clearing the array at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.idx] <= 1'b1;
			end
			if (rd.en) begin
				rd_vld_s1 <= valid_q[rd.idx];
			end
		end
	end

endmodule

>>> src/byte_half_word_data_memory.sv
// Top level of the byte/half/word data memory.
// One load or store request is taken per cycle; its result (the extended
// load value, or 0 for stores and out-of-range loads) appears in the next
// cycle, taken from the registered read port of the word store. A result held
// by out_stall holds off the next request. Byte order is little-endian, half
// and word addresses are aligned down, out-of-range stores are dropped. Reset
// clears the contents at once through per-word valid flags, with no sweep.
module byte_half_word_data_memory (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [31:0] address,
	input  logic [31:0] store_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data
);

	logic               accept;
	logic               byte_ok, half_ok, word_ok;
	logic               range_ok, is_load;
	bhwdm_pkg::wr_req_t wr;
	bhwdm_pkg::rd_req_t rd;
	logic [31:0]        rd_word_s1;
	logic               rd_vld_s1;
	logic               valid_s1;
	logic [2:0]         kind_s1;
	logic [1:0]         lane_s1;
	logic               ok_s1;
	logic [31:0]        word_s1;
	logic [7:0]         byte_s1;
	logic [15:0]        half_s1;

	// Handshake: stall only while a result waits
	assign in_stall = valid_s1 && out_stall;
	assign accept   = in_valid && !in_stall;
	assign out_valid = valid_s1;

	// Range checks
	assign byte_ok = address < bhwdm_pkg::BYTE_LIMIT;
	assign half_ok = address[31:1] < bhwdm_pkg::HALF_LIMIT;
	assign word_ok = address[31:2] < bhwdm_pkg::WORD_LIMIT;

	// Decode kind into lane enables, lane data and range
	always_comb begin
		wr.en   = 1'b0;
		wr.be   = 4'b0000;
		wr.idx  = address[bhwdm_pkg::IDX_W+1:2];
		wr.data = store_value;
		is_load = 1'b0;
		range_ok = 1'b0;
		unique case (kind) inside
			bhwdm_pkg::KIND_SB: begin
				range_ok = byte_ok;
				wr.be    = 4'b0001 << address[1:0];
				wr.data  = {4{store_value[7:0]}};
			end
			bhwdm_pkg::KIND_SH: begin
				range_ok = half_ok;
				wr.be    = address[1] ? 4'b1100 : 4'b0011;
				wr.data  = {2{store_value[15:0]}};
			end
			bhwdm_pkg::KIND_SW: begin
				range_ok = word_ok;
				wr.be    = 4'b1111;
			end
			bhwdm_pkg::KIND_LB, bhwdm_pkg::KIND_LBU: begin
				range_ok = byte_ok;
				is_load  = 1'b1;
			end
			bhwdm_pkg::KIND_LH, bhwdm_pkg::KIND_LHU: begin
				range_ok = half_ok;
				is_load  = 1'b1;
			end
			default: begin
				range_ok = word_ok;
				is_load  = 1'b1;
			end
		endcase
		wr.en = accept && !is_load && range_ok;
	end

	assign rd.en  = accept;
	assign rd.idx = address[bhwdm_pkg::IDX_W+1:2];

	bhwdm_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.rd        (rd),
		.rd_word_s1(rd_word_s1),
		.rd_vld_s1 (rd_vld_s1)
	);

	// Result stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (!out_stall) begin
			valid_s1 <= 1'b0;
		end
	end

	// Result stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			lane_s1 <= address[1:0];
			ok_s1   <= is_load && range_ok;
		end
	end

	// Lane select and extension
	assign word_s1 = rd_vld_s1 ? rd_word_s1 : 32'h0;
	assign byte_s1 = word_s1[8*lane_s1 +: 8];
	assign half_s1 = lane_s1[1] ? word_s1[31:16] : word_s1[15:0];

	always_comb begin
		read_data = 32'h0;
		if (ok_s1) begin
			case (kind_s1)
				bhwdm_pkg::KIND_LB:  read_data = {{24{byte_s1[7]}}, byte_s1};
				bhwdm_pkg::KIND_LBU: read_data = {24'h0, byte_s1};
				bhwdm_pkg::KIND_LH:  read_data = {{16{half_s1[15]}}, half_s1};
				bhwdm_pkg::KIND_LHU: read_data = {16'h0, half_s1};
				bhwdm_pkg::KIND_LW:  read_data = word_s1;
				default:             read_data = 32'h0;
			endcase
		end
	end

endmodule

>>> src/bhwdm_checker.sv
// Port-level checks for the data memory, bound to the top level.
module bhwdm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [2:0]  kind,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] read_data
);

	// A held result keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_data))
		else $error("held result changed");

	// Every accepted request yields a result in the next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("result missing one cycle after request");

	// Input is held off only by a waiting, stalled result
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a waiting result");

	// Stores answer zero
	a_store_zero: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (kind == bhwdm_pkg::KIND_SB ||
		kind == bhwdm_pkg::KIND_SH || kind == bhwdm_pkg::KIND_SW)
		|=> read_data == 32'h0)
		else $error("store answered nonzero");

	// Unsigned byte loads are zero-extended
	a_lbu_ext: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && kind == bhwdm_pkg::KIND_LBU
		|=> read_data[31:8] == 24'h0)
		else $error("unsigned byte load not zero-extended");

endmodule

bind byte_half_word_data_memory bhwdm_checker u_bhwdm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.kind     (kind),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.read_data(read_data)
);

>>> bench/byte_half_word_data_memory_test.sv
// Self-checking testbench for the byte/half/word data memory: directed, backpressure and random runs.
module byte_half_word_data_memory_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 160;
	localparam int DRAIN_CYCLES = 8;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  kind;
	logic [31:0] address;
	logic [31:0] store_value;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] read_data;

	// Shadow copy of the word store and the reads still owed by the block
	logic [31:0] shadow_words [bhwdm_pkg::WORD_DEPTH];
	logic [31:0] pending_reads [$];

	bit src_idling;
	bit sink_idling;
	bit hold_request;
	int mismatches;
	int cycle_count;
	int store_count;
	int load_count;
	int beyond_count;
	int longest_hold;

	byte_half_word_data_memory DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.address(address),
		.store_value(store_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_data(read_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d reads still owed",
				$time, cycle_count, pending_reads.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic [7:0] shadow_byte(logic [31:0] b);
		bhwdm_pkg::word_idx_t idx;
		idx = b[bhwdm_pkg::IDX_W+1:2];
		return shadow_words[idx][8*b[1:0] +: 8];
	endfunction

	task automatic shadow_write_byte(logic [31:0] b, logic [7:0] v);
		bhwdm_pkg::word_idx_t idx;
		idx = b[bhwdm_pkg::IDX_W+1:2];
		shadow_words[idx][8*b[1:0] +: 8] = v;
	endtask

	// Work out the read data of one accepted request and update the shadow store
	task automatic predict_access(input logic [2:0] k, input logic [31:0] a,
		input logic [31:0] v, output logic [31:0] rd);
		logic        byte_ok;
		logic        half_ok;
		logic        word_ok;
		logic [31:0] half_base;
		logic [15:0] half_val;
		logic [7:0]  byte_val;
		byte_ok = a < bhwdm_pkg::BYTE_LIMIT;
		half_ok = a[31:1] < bhwdm_pkg::HALF_LIMIT;
		word_ok = a[31:2] < bhwdm_pkg::WORD_LIMIT;
		half_base = {a[31:1], 1'b0};
		rd = '0;
		case (k)
			bhwdm_pkg::KIND_SB: begin
				if (byte_ok) shadow_write_byte(a, v[7:0]);
			end
			bhwdm_pkg::KIND_SH: begin
				if (half_ok) begin
					shadow_write_byte(half_base, v[7:0]);
					shadow_write_byte(half_base + 32'd1, v[15:8]);
				end
			end
			bhwdm_pkg::KIND_SW: begin
				if (word_ok) shadow_words[bhwdm_pkg::word_idx_t'(a[31:2])] = v;
			end
			bhwdm_pkg::KIND_LB: begin
				if (byte_ok) begin
					byte_val = shadow_byte(a);
					rd = {{24{byte_val[7]}}, byte_val};
				end
			end
			bhwdm_pkg::KIND_LH: begin
				if (half_ok) begin
					half_val = {shadow_byte(half_base + 32'd1), shadow_byte(half_base)};
					rd = {{16{half_val[15]}}, half_val};
				end
			end
			bhwdm_pkg::KIND_LW: begin
				if (word_ok) rd = shadow_words[bhwdm_pkg::word_idx_t'(a[31:2])];
			end
			bhwdm_pkg::KIND_LBU: begin
				if (byte_ok) rd = {24'd0, shadow_byte(a)};
			end
			default: begin
				if (half_ok)
					rd = {16'd0, shadow_byte(half_base + 32'd1), shadow_byte(half_base)};
			end
		endcase
		if (k == bhwdm_pkg::KIND_SB || k == bhwdm_pkg::KIND_SH || k == bhwdm_pkg::KIND_SW)
			store_count++;
		else
			load_count++;
		if ((k == bhwdm_pkg::KIND_SB || k == bhwdm_pkg::KIND_LB ||
			k == bhwdm_pkg::KIND_LBU) ? !byte_ok :
			(k == bhwdm_pkg::KIND_SW || k == bhwdm_pkg::KIND_LW) ? !word_ok : !half_ok)
			beyond_count++;
	endtask

	// Offer one request, hold it until accepted, then log the expected read
	task automatic send_access(logic [2:0] k, logic [31:0] a, logic [31:0] v);
		int          gap;
		logic [31:0] rd;
		gap = (src_idling && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid    <= 1'b1;
		kind        <= k;
		address     <= a;
		store_value <= v;
		do @(posedge clk); while (in_stall !== 1'b0);
		predict_access(k, a, v, rd);
		pending_reads.push_back(rd);
	endtask

	// Result checker
	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_reads.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, read_data);
				mismatches++;
			end else begin
				want = pending_reads.pop_front();
				if (read_data !== want) begin
					$display("%0t: read_data mismatch, expected %h, actual %h",
						$time, want, read_data);
					mismatches++;
				end
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold-off on request
	initial begin : receiver
		int n;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				n = 0;
				while (n < HOLD_CYCLES) begin
					@(negedge clk);
					n++;
				end
				if (n > longest_hold) longest_hold = n;
				out_stall <= 1'b0;
			end else if (sink_idling && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 6);
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	function automatic logic [31:0] pick_address();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return $urandom_range(0, bhwdm_pkg::MEM_BYTES - 1);
			6, 7: return $urandom_range(bhwdm_pkg::MEM_BYTES - 8, bhwdm_pkg::MEM_BYTES + 7);
			8:                return $urandom;
			default:          return 32'hFFFF_FFFF - $urandom_range(0, 7);
		endcase
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Field extremes, every access kind, sign and zero extension, alignment, range edges
	task automatic test_directed_edges();
		send_access(bhwdm_pkg::KIND_LW,  32'd0, 32'hFFFF_FFFF);
		send_access(bhwdm_pkg::KIND_LBU, bhwdm_pkg::MEM_BYTES - 1, 32'd0);
		send_access(bhwdm_pkg::KIND_SW,  32'd0, 32'h80FF_7F01);
		send_access(bhwdm_pkg::KIND_LB,  32'd1, 32'd0);
		send_access(bhwdm_pkg::KIND_LB,  32'd2, 32'd0);
		send_access(bhwdm_pkg::KIND_LB,  32'd3, 32'd0);
		send_access(bhwdm_pkg::KIND_LBU, 32'd3, 32'd0);
		send_access(bhwdm_pkg::KIND_LH,  32'd2, 32'd0);
		send_access(bhwdm_pkg::KIND_LHU, 32'd3, 32'd0);
		send_access(bhwdm_pkg::KIND_LH,  32'd1, 32'd0);
		send_access(bhwdm_pkg::KIND_LW,  32'd3, 32'd0);
		send_access(bhwdm_pkg::KIND_SH,  32'd5, 32'hDEAD_BEEF);
		send_access(bhwdm_pkg::KIND_LW,  32'd4, 32'd0);
		send_access(bhwdm_pkg::KIND_SB,  bhwdm_pkg::MEM_BYTES - 1, 32'hFFFF_FF80);
		send_access(bhwdm_pkg::KIND_LB,  bhwdm_pkg::MEM_BYTES - 1, 32'd0);
		send_access(bhwdm_pkg::KIND_LW,  bhwdm_pkg::MEM_BYTES - 1, 32'd0);
		send_access(bhwdm_pkg::KIND_LHU, bhwdm_pkg::MEM_BYTES - 1, 32'd0);
		// beyond the end: stores dropped, loads read zero, unsigned ones too
		send_access(bhwdm_pkg::KIND_SB,  bhwdm_pkg::MEM_BYTES, 32'hFFFF_FFFF);
		send_access(bhwdm_pkg::KIND_SW,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_access(bhwdm_pkg::KIND_SH,  bhwdm_pkg::MEM_BYTES + 1, 32'hFFFF_FFFF);
		send_access(bhwdm_pkg::KIND_LBU, bhwdm_pkg::MEM_BYTES, 32'd0);
		send_access(bhwdm_pkg::KIND_LHU, 32'hFFFF_FFFF, 32'd0);
		send_access(bhwdm_pkg::KIND_LW,  32'hFFFF_FFFC, 32'd0);
		send_access(bhwdm_pkg::KIND_LB,  32'h8000_0000, 32'd0);
		send_access(bhwdm_pkg::KIND_LW,  bhwdm_pkg::MEM_BYTES - 4, 32'd0);
	endtask

	// Receiver holds off while the sender keeps offering back-to-back requests
	task automatic test_backpressure_fill();
		hold_request = 1'b1;
		for (int i = 0; i < 30; i++)
			send_access(3'($urandom_range(0, 7)), $urandom_range(0, 63), pick_value());
	endtask

	// Mostly store-then-load pairs in the same word, the rest loose accesses
	task automatic test_random_traffic(int count);
		logic [31:0] a;
		int          sent;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 9) < 6) begin
				a = $urandom_range(0, 9) == 0 ? pick_address() :
					$urandom_range(0, bhwdm_pkg::MEM_BYTES - 1);
				send_access(3'($urandom_range(bhwdm_pkg::KIND_SB, bhwdm_pkg::KIND_SW)), a,
					pick_value());
				send_access(3'($urandom_range(bhwdm_pkg::KIND_LB, bhwdm_pkg::KIND_LHU)),
					a ^ 32'($urandom_range(0, 3)), pick_value());
				sent += 2;
			end else begin
				send_access(3'($urandom_range(0, 7)), pick_address(), pick_value());
				sent++;
			end
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		kind         = bhwdm_pkg::KIND_SB;
		address      = '0;
		store_value  = '0;
		src_idling   = 1'b0;
		sink_idling  = 1'b0;
		hold_request = 1'b0;
		foreach (shadow_words[i]) shadow_words[i] = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		src_idling  = 1'b1;
		sink_idling = 1'b1;
		test_directed_edges();
		src_idling  = 1'b0;
		sink_idling = 1'b0;
		test_backpressure_fill();
		src_idling  = 1'b1;
		sink_idling = 1'b1;
		test_random_traffic(1000);
		// closing stretch at full rate
		src_idling  = 1'b0;
		sink_idling = 1'b0;
		test_random_traffic(250);

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_reads.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d requests: %0d stores, %0d loads, %0d beyond the memory.",
			store_count + load_count, store_count, load_count, beyond_count);
		$display("Longest receiver hold-off %0d cycles, %0d mismatches.", longest_hold, mismatches);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
